/* hw/rtl/fct_pkg.sv */
// Shared types and constants for the six-plane frustum cull test.
`timescale 1ns / 1ps

package fct_pkg;

  localparam int unsigned NUM_PLANES  = 6;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned COMP_W      = 16;   // one plane or vector component
  localparam int unsigned AXIS_W      = 48;   // packed x, y, z
  localparam int unsigned RADIUS_W    = 15;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned PROD_W      = 32;   // Q2.14 times Q12.4
  localparam int unsigned PROJ_W      = 33;   // sum of three products
  localparam int unsigned DIST_W      = 34;   // projection plus scaled d
  localparam int unsigned CMP_W       = 35;   // common width for the compare
  localparam int unsigned FRAC_SHIFT  = 14;   // aligns Q12.4 with Q.18
  localparam int unsigned IN_DATA_W   = 208;
  localparam int unsigned OUT_DATA_W  = 8;

  // Test kinds carried on the input tuser; anything else is a box.
  localparam logic [CMD_W-1:0] CMD_POINT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SPHERE = 2'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    PLANE_NEAR   = 3'd0,
    PLANE_FAR    = 3'd1,
    PLANE_LEFT   = 3'd2,
    PLANE_RIGHT  = 3'd3,
    PLANE_BOTTOM = 3'd4,
    PLANE_TOP    = 3'd5
  } plane_idx_t;

  // One object in flight, plus the running verdict.
  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [COMP_W-1:0]   center_x;
    logic [COMP_W-1:0]   center_y;
    logic [COMP_W-1:0]   center_z;
    logic [RADIUS_W-1:0] radius;
    logic [AXIS_W-1:0]   half_axis_a;
    logic [AXIS_W-1:0]   half_axis_b;
    logic [AXIS_W-1:0]   half_axis_c;
    logic                alive;
  } item_t;

endpackage

/* hw/rtl/fct_cell.sv */
// One plane cell: holds a plane and tests each passing object against it.
`timescale 1ns / 1ps

module fct_cell import fct_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  up_valid,
  input  item_t                 up_item,
  output logic                  up_ready,
  output logic                  dn_valid,
  output item_t                 dn_item,
  input  logic                  dn_ready
);

  logic [CFG_DATA_W-1:0] plane_r;

  logic  v1_r, v2_r, v3_r;
  logic  rdy1, rdy2, rdy3;
  item_t item1_r, item2_r, item3_r;

  // stage 1: twelve products
  logic signed [PROD_W-1:0] pc_nxt [3];
  logic signed [PROD_W-1:0] pa_nxt [3];
  logic signed [PROD_W-1:0] pb_nxt [3];
  logic signed [PROD_W-1:0] px_nxt [3];
  logic signed [PROD_W-1:0] pc_r   [3];
  logic signed [PROD_W-1:0] pa_r   [3];
  logic signed [PROD_W-1:0] pb_r   [3];
  logic signed [PROD_W-1:0] px_r   [3];

  // stage 2: distance and absolute axis projections
  logic signed [DIST_W-1:0] dist_nxt, dist_r;
  logic signed [PROJ_W-1:0] proj_a, proj_b, proj_c;
  logic [PROJ_W-1:0]        neg_a, neg_b, neg_c;
  logic [PROD_W-1:0]        abs_a_nxt, abs_b_nxt, abs_c_nxt;
  logic [PROD_W-1:0]        abs_a_r, abs_b_r, abs_c_r;

  // stage 3: threshold and compare
  logic [DIST_W-1:0]        ext;
  logic signed [CMP_W-1:0]  thr;
  logic signed [CMP_W-1:0]  dist_cmp;
  logic                     reject;
  item_t                    item3_nxt;

  logic signed [COMP_W-1:0] n [3];
  logic signed [COMP_W-1:0] d;
  logic signed [COMP_W-1:0] ctr [3];
  logic signed [COMP_W-1:0] ax_a [3];
  logic signed [COMP_W-1:0] ax_b [3];
  logic signed [COMP_W-1:0] ax_c [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else if (cfg_we) begin
      plane_r <= cfg_data;
    end
  end

  // Each stage advances when the one after it is empty or moving.
  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n[k]    = $signed(plane_r[k*COMP_W +: COMP_W]);
      ax_a[k] = $signed(up_item.half_axis_a[k*COMP_W +: COMP_W]);
      ax_b[k] = $signed(up_item.half_axis_b[k*COMP_W +: COMP_W]);
      ax_c[k] = $signed(up_item.half_axis_c[k*COMP_W +: COMP_W]);
    end
    d      = $signed(plane_r[3*COMP_W +: COMP_W]);
    ctr[0] = $signed(up_item.center_x);
    ctr[1] = $signed(up_item.center_y);
    ctr[2] = $signed(up_item.center_z);
    for (int k = 0; k < 3; k++) begin
      pc_nxt[k] = PROD_W'(n[k]) * PROD_W'(ctr[k]);
      pa_nxt[k] = PROD_W'(n[k]) * PROD_W'(ax_a[k]);
      pb_nxt[k] = PROD_W'(n[k]) * PROD_W'(ax_b[k]);
      px_nxt[k] = PROD_W'(n[k]) * PROD_W'(ax_c[k]);
    end
  end

  always_comb begin
    dist_nxt = DIST_W'(pc_r[0]) + DIST_W'(pc_r[1]) + DIST_W'(pc_r[2])
             + (DIST_W'(d) <<< FRAC_SHIFT);
    proj_a   = PROJ_W'(pa_r[0]) + PROJ_W'(pa_r[1]) + PROJ_W'(pa_r[2]);
    proj_b   = PROJ_W'(pb_r[0]) + PROJ_W'(pb_r[1]) + PROJ_W'(pb_r[2]);
    proj_c   = PROJ_W'(px_r[0]) + PROJ_W'(px_r[1]) + PROJ_W'(px_r[2]);
    neg_a    = proj_a[PROJ_W-1] ? -proj_a : proj_a;
    neg_b    = proj_b[PROJ_W-1] ? -proj_b : proj_b;
    neg_c    = proj_c[PROJ_W-1] ? -proj_c : proj_c;
    abs_a_nxt = neg_a[PROD_W-1:0];
    abs_b_nxt = neg_b[PROD_W-1:0];
    abs_c_nxt = neg_c[PROD_W-1:0];
  end

  // Point rejects on dist > 0, i.e. dist >= 1.
  always_comb begin
    ext      = DIST_W'(abs_a_r) + DIST_W'(abs_b_r) + DIST_W'(abs_c_r);
    dist_cmp = CMP_W'(dist_r);
    if (item2_r.cmd == CMD_POINT) begin
      thr = CMP_W'(1);
    end else if (item2_r.cmd == CMD_SPHERE) begin
      thr = $signed({6'b0, item2_r.radius, {FRAC_SHIFT{1'b0}}});
    end else begin
      thr = $signed({1'b0, ext});
    end
    reject          = dist_cmp >= thr;
    item3_nxt       = item2_r;
    item3_nxt.alive = item2_r.alive && !reject;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      item1_r <= up_item;
      pc_r    <= pc_nxt;
      pa_r    <= pa_nxt;
      pb_r    <= pb_nxt;
      px_r    <= px_nxt;
    end
    if (rdy2 && v1_r) begin
      item2_r <= item1_r;
      dist_r  <= dist_nxt;
      abs_a_r <= abs_a_nxt;
      abs_b_r <= abs_b_nxt;
      abs_c_r <= abs_c_nxt;
    end
    if (rdy3 && v2_r) begin
      item3_r <= item3_nxt;
    end
  end

  assign dn_valid = v3_r;
  assign dn_item  = item3_r;

endmodule

/* hw/rtl/frustum_cull_test.sv */
// Top level of the six-plane frustum cull test: a row of plane cells.
//
//   channel | direction | ports                               | payload
//   --------+-----------+-------------------------------------+-----------------------------
//   in      | sink      | in_tvalid, in_tready, in_tdata/user | one object to test
//   out     | source    | out_tvalid, out_tready, out_tdata   | inside flag
//   cfg     | sink      | cfg_valid, cfg_ready, cfg_index/data| one 64-bit plane register
//
// Throughput is one item per clock while out_tready is high; each plane cell is a
// three-stage pipe (multiply, sum and absolute value, compare), so 18 registers lie
// between input and output. Six cells in a row, one per plane, hand the item and
// its running verdict along. Stage-local ready lets bubbles squeeze out while
// out_tready is low. Reset (rst_n low, synchronous) empties the pipe and clears
// all six planes to zero. cfg_ready is always high.
`timescale 1ns / 1ps

module frustum_cull_test import fct_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // center_x[15:0], center_y[31:16], center_z[47:32], radius[62:48],
  // half_axis_a[110:63], half_axis_b[158:111], half_axis_c[206:159], zero[207]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // cmd[1:0]
  input  logic [CMD_W-1:0]      in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // inside_res[0], zero[7:1]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                  link_valid [NUM_PLANES+1];
  logic                  link_ready [NUM_PLANES+1];
  item_t                 link_item  [NUM_PLANES+1];
  logic [NUM_PLANES-1:0] plane_we;

  // Unpack the incoming item; every object starts out inside.
  always_comb begin
    link_item[0].cmd         = in_tuser;
    link_item[0].center_x    = in_tdata[15:0];
    link_item[0].center_y    = in_tdata[31:16];
    link_item[0].center_z    = in_tdata[47:32];
    link_item[0].radius      = in_tdata[62:48];
    link_item[0].half_axis_a = in_tdata[110:63];
    link_item[0].half_axis_b = in_tdata[158:111];
    link_item[0].half_axis_c = in_tdata[206:159];
    link_item[0].alive       = 1'b1;
  end

  assign link_valid[0] = in_tvalid;
  assign in_tready     = link_ready[0];

  // Decode the plane write; indexes past the top plane drop silently.
  assign cfg_ready = 1'b1;

  always_comb begin
    plane_we = '0;
    case (plane_idx_t'(cfg_index))
      PLANE_NEAR:   plane_we[0] = cfg_valid;
      PLANE_FAR:    plane_we[1] = cfg_valid;
      PLANE_LEFT:   plane_we[2] = cfg_valid;
      PLANE_RIGHT:  plane_we[3] = cfg_valid;
      PLANE_BOTTOM: plane_we[4] = cfg_valid;
      PLANE_TOP:    plane_we[5] = cfg_valid;
      default:      plane_we    = '0;
    endcase
  end

  // Chain of plane cells; each ANDs its own verdict into the item.
  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
    fct_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cfg_we   (plane_we[i]),
      .cfg_data (cfg_data),
      .up_valid (link_valid[i]),
      .up_item  (link_item[i]),
      .up_ready (link_ready[i]),
      .dn_valid (link_valid[i+1]),
      .dn_item  (link_item[i+1]),
      .dn_ready (link_ready[i+1])
    );
  end

  // The last cell's final stage is the output register.
  assign out_tvalid               = link_valid[NUM_PLANES];
  assign link_ready[NUM_PLANES]   = out_tready;
  assign out_tdata                = {7'b0, link_item[NUM_PLANES].alive};

endmodule
